// ===== rtl/hst_pkg.sv =====
// shared token codes, lexer modes and character class helpers
`timescale 1ns / 1ps
package hst_pkg;

   localparam int LINE_BITS_DEFAULT   = 16;
   localparam int COLUMN_BITS_DEFAULT = 12;
   localparam int MAX_EMITS           = 3;
   localparam int KIND_BITS           = 6;
   localparam int LEN_BITS            = 8;
   localparam int ERR_BITS            = 3;
   localparam logic [3:0] INDENT_WIDTH_RESET = 4'd4;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_KWORD, MODE_AWORD, MODE_NUMBER, MODE_OPER, MODE_COMMENT
   } lex_mode_type;

   localparam logic [2:0] ERR_NONE = 3'd0, ERR_SHORT_INDENT = 3'd1,
      ERR_TAB_INDENT = 3'd2, ERR_BAD_REAL = 3'd3, ERR_INCREMENT = 3'd4;

   localparam logic [5:0]
      K_UNDEF = 6'd0, K_EOF = 6'd1, K_NEWLINE = 6'd2, K_INDENT = 6'd3, K_IDENT = 6'd4,
      K_INT = 6'd5, K_REAL = 6'd6, K_HI = 6'd7, K_GO = 6'd8, K_IJ = 6'd9, K_NO = 6'd10,
      K_NOPE = 6'd11, K_GG = 6'd12, K_SG = 6'd13, K_TT = 6'd14, K_TRUE = 6'd15,
      K_FALSE = 6'd16, K_COMMA = 6'd17, K_COLON = 6'd18, K_SEMI = 6'd19,
      K_LPAR = 6'd20, K_RPAR = 6'd21, K_LSQ = 6'd22, K_RSQ = 6'd23, K_LBR = 6'd24,
      K_RBR = 6'd25, K_DOT = 6'd26, K_DQ = 6'd27, K_SQ = 6'd28, K_ANNO = 6'd29,
      K_VAARG = 6'd30, K_ADD = 6'd31, K_SUB = 6'd32, K_MUL = 6'd33, K_DIV = 6'd34,
      K_MOD = 6'd35, K_AND = 6'd36, K_OR = 6'd37, K_NOT = 6'd38, K_BAND = 6'd39,
      K_BOR = 6'd40, K_BNOT = 6'd41, K_BXOR = 6'd42, K_LSH = 6'd43, K_RSH = 6'd44,
      K_ASSN = 6'd45, K_MULA = 6'd46, K_DIVA = 6'd47, K_MODA = 6'd48,
      K_ADDA = 6'd49, K_SUBA = 6'd50, K_LSHA = 6'd51, K_RSHA = 6'd52,
      K_ANDA = 6'd53, K_ORA = 6'd54, K_XORA = 6'd55, K_EQ = 6'd56, K_NE = 6'd57,
      K_GT = 6'd58, K_GE = 6'd59, K_LT = 6'd60, K_LE = 6'd61;

   function automatic logic is_kor(input logic [20:0] c);
      return (c >= 21'hAC00 && c <= 21'hD7A3) || (c >= 21'h3131 && c <= 21'h318E);
   endfunction

   function automatic logic is_digit(input logic [20:0] c);
      return c >= 21'h30 && c <= 21'h39;
   endfunction

   function automatic logic is_alpha(input logic [20:0] c);
      return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A);
   endfunction

   function automatic logic is_blank(input logic [20:0] c);
      return c == 21'h20 || c == 21'h09 || c == 21'h0B || c == 21'h0C || c == 21'h0D;
   endfunction

   // msb set when the text is an operator
   function automatic logic [6:0] oper_lookup(input logic [23:0] t);
      logic [6:0] r;
      r = 7'd0;
      case (t)
         24'h00002C: r = {1'b1, K_COMMA};
         24'h00003A: r = {1'b1, K_COLON};
         24'h00003B: r = {1'b1, K_SEMI};
         24'h000028: r = {1'b1, K_LPAR};
         24'h000029: r = {1'b1, K_RPAR};
         24'h00005B: r = {1'b1, K_LSQ};
         24'h00005D: r = {1'b1, K_RSQ};
         24'h00007B: r = {1'b1, K_LBR};
         24'h00007D: r = {1'b1, K_RBR};
         24'h000022: r = {1'b1, K_DQ};
         24'h000027: r = {1'b1, K_SQ};
         24'h002F2F: r = {1'b1, K_ANNO};
         24'h00002B: r = {1'b1, K_ADD};
         24'h00002D: r = {1'b1, K_SUB};
         24'h00002A: r = {1'b1, K_MUL};
         24'h00002F: r = {1'b1, K_DIV};
         24'h000025: r = {1'b1, K_MOD};
         24'h002626: r = {1'b1, K_AND};
         24'h007C7C: r = {1'b1, K_OR};
         24'h000021: r = {1'b1, K_NOT};
         24'h000026: r = {1'b1, K_BAND};
         24'h00007C: r = {1'b1, K_BOR};
         24'h00007E: r = {1'b1, K_BNOT};
         24'h00005E: r = {1'b1, K_BXOR};
         24'h003C3C: r = {1'b1, K_LSH};
         24'h003E3E: r = {1'b1, K_RSH};
         24'h00003D: r = {1'b1, K_ASSN};
         24'h003D2A: r = {1'b1, K_MULA};
         24'h003D2F: r = {1'b1, K_DIVA};
         24'h003D25: r = {1'b1, K_MODA};
         24'h003D2B: r = {1'b1, K_ADDA};
         24'h003D2D: r = {1'b1, K_SUBA};
         24'h3D3C3C: r = {1'b1, K_LSHA};
         24'h3D3E3E: r = {1'b1, K_RSHA};
         24'h003D26: r = {1'b1, K_ANDA};
         24'h003D7C: r = {1'b1, K_ORA};
         24'h003D5E: r = {1'b1, K_XORA};
         24'h003D3D: r = {1'b1, K_EQ};
         24'h003D21: r = {1'b1, K_NE};
         24'h00003E: r = {1'b1, K_GT};
         24'h003D3E: r = {1'b1, K_GE};
         24'h00003C: r = {1'b1, K_LT};
         24'h003D3C: r = {1'b1, K_LE};
         default:    r = 7'd0;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] word_kind(input logic [20:0] p0, input logic [20:0] p1,
                                            input logic [20:0] p2, input logic [7:0] n);
      logic [5:0] k;
      k = K_IDENT;
      if (p0 == 21'h314E && p1 == 21'h3147 && p2 == 21'h0 && n == 8'd6) k = K_HI;
      if (p0 == 21'h3131 && p1 == 21'h3131 && p2 == 21'h0 && n == 8'd6) k = K_GO;
      if (p0 == 21'h3147 && p1 == 21'h3148 && p2 == 21'h3F && n == 8'd7) k = K_IJ;
      if (p0 == 21'h3134 && p1 == 21'h3134 && p2 == 21'h3F && n == 8'd7) k = K_NO;
      if (p0 == 21'h3134 && p1 == 21'h3134 && p2 == 21'h0 && n == 8'd6) k = K_NOPE;
      if (p0 == 21'h3148 && p1 == 21'h3148 && p2 == 21'h0 && n == 8'd6) k = K_GG;
      if (p0 == 21'h3145 && p1 == 21'h3131 && p2 == 21'h0 && n == 8'd6) k = K_SG;
      if (p0 == 21'h314C && p1 == 21'h314C && p2 == 21'h0 && n == 8'd6) k = K_TT;
      if (p0 == 21'hCC38 && p1 == 21'h0 && p2 == 21'h0 && n == 8'd3) k = K_TRUE;
      if (p0 == 21'hAC70 && p1 == 21'hC9D3 && p2 == 21'h0 && n == 8'd6) k = K_FALSE;
      return k;
   endfunction

endpackage

// ===== rtl/hst_lexer.sv =====
// utf-8 decode, position tracking, token recognition; a byte per step cycle
`timescale 1ns / 1ps
module hst_lexer #(
   parameter int LINE_BITS   = hst_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = hst_pkg::COLUMN_BITS_DEFAULT,
   parameter int EW          = 6 + LINE_BITS + COLUMN_BITS + 8 + 3 + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               action,
   input  logic [7:0]                         data_byte,
   input  logic                               cfg_write,
   input  logic [3:0]                         cfg_data,
   output logic [hst_pkg::MAX_EMITS-1:0]      emit_valid,
   output logic [hst_pkg::MAX_EMITS-1:0][EW-1:0] emit_data
);
   import hst_pkg::*;

   logic [3:0]             iw_ff;
   logic                   als_ff, als_in;
   lex_mode_type           mode_ff, mode_in;
   logic [20:0]            acc_ff, acc_in;
   logic [1:0]             left_ff, left_in;
   logic [2:0]             ulen_ff, ulen_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tl_ff, tl_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, tc_ff, tc_in;
   logic [7:0]             wc_ff, wc_in;
   logic [20:0]            p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic [23:0]            op_ff, op_in;
   logic [2:0]             nf_ff, nf_in, sr_ff, sr_in, pend_ff, pend_in;

   logic                   go, eof, done;
   logic [20:0]            cp;
   logic [2:0]             nb;
   logic [3:0]             w, sr4;
   logic [8:0]             wsum;
   logic [1:0]             plen;
   logic [23:0]            cand;
   logic [6:0]             look;
   logic [5:0]             e_kind [3];
   logic [LINE_BITS-1:0]   e_line [3];
   logic [COLUMN_BITS-1:0] e_col [3];
   logic [7:0]             e_len [3];
   logic [2:0]             e_err [3];

   always_comb begin
      als_in = als_ff; mode_in = mode_ff; acc_in = acc_ff; left_in = left_ff;
      ulen_in = ulen_ff; line_in = line_ff; col_in = col_ff; tl_in = tl_ff;
      tc_in = tc_ff; wc_in = wc_ff; p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      op_in = op_ff; nf_in = nf_ff; sr_in = sr_ff; pend_in = pend_ff;
      go = 1'b0; eof = 1'b0; done = 1'b0; cp = 21'd0; nb = 3'd0;
      sr4 = 4'd0; wsum = 9'd0; plen = 2'd0; cand = 24'd0; look = 7'd0;
      emit_valid = '0;
      for (int i = 0; i < MAX_EMITS; i++) begin
         e_kind[i] = K_UNDEF; e_line[i] = '0; e_col[i] = '0;
         e_len[i] = 8'd0; e_err[i] = ERR_NONE;
      end
      w = (iw_ff == 4'd0) ? 4'd1 : ((iw_ff > 4'd8) ? 4'd8 : iw_ff);

      // utf-8 front end
      if (step) begin
         if (action) begin
            acc_in = 21'd0; left_in = 2'd0; ulen_in = 3'd0;
            go = 1'b1; eof = 1'b1;
         end else if (left_ff != 2'd0) begin
            acc_in = {acc_ff[14:0], data_byte[5:0]};
            left_in = left_ff - 2'd1;
            if (left_ff == 2'd1) begin
               cp = acc_in; nb = ulen_ff; acc_in = 21'd0; go = 1'b1;
            end
         end else if ((data_byte & 8'hE0) == 8'hC0) begin
            acc_in = {16'd0, data_byte[4:0]}; left_in = 2'd1; ulen_in = 3'd2;
         end else if ((data_byte & 8'hF0) == 8'hE0) begin
            acc_in = {17'd0, data_byte[3:0]}; left_in = 2'd2; ulen_in = 3'd3;
         end else if ((data_byte & 8'hF8) == 8'hF0) begin
            acc_in = {18'd0, data_byte[2:0]}; left_in = 2'd3; ulen_in = 3'd4;
         end else begin
            cp = {13'd0, data_byte}; nb = 3'd1; go = 1'b1;
         end
      end

      if (go) begin
         if (col_in != '1) col_in = col_in + 1'b1;
         // indent handling at line start
         if (als_in) begin
            if (!eof && cp == 21'h20) begin
               if (sr_in == 3'd0) begin
                  tl_in = line_in; tc_in = col_in; wc_in = 8'd0;
               end
               sr4 = {1'b0, sr_in} + 4'd1;
               if (sr4 >= w) begin
                  emit_valid[0] = 1'b1; e_kind[0] = K_INDENT; e_line[0] = tl_in;
                  e_col[0] = tc_in; e_len[0] = {4'd0, sr4}; e_err[0] = pend_in;
                  pend_in = ERR_NONE; sr4 = 4'd0;
               end
               sr_in = sr4[2:0]; done = 1'b1;
            end else begin
               if (sr_in != 3'd0) begin
                  emit_valid[0] = 1'b1; e_kind[0] = K_INDENT; e_line[0] = tl_in;
                  e_col[0] = tc_in; e_len[0] = {5'd0, sr_in}; e_err[0] = ERR_SHORT_INDENT;
                  pend_in = ERR_NONE; sr_in = 3'd0;
               end
               als_in = 1'b0;
               if (!eof && cp == 21'h09) begin
                  pend_in = ERR_TAB_INDENT; done = 1'b1;
               end
            end
         end

         // close or extend the open token
         if (!done) begin
            e_line[1] = tl_in; e_col[1] = tc_in;
            wsum = {1'b0, wc_in} + {6'd0, nb};
            case (mode_in)
               MODE_KWORD: begin
                  if (!eof && (is_kor(cp) || is_digit(cp) || cp == 21'h5F || cp == 21'h3F))
                  begin
                     wc_in = wsum[8] ? 8'hFF : wsum[7:0];
                     if (p0_in == 21'd0) p0_in = cp;
                     else if (p1_in == 21'd0) p1_in = cp;
                     else if (p2_in == 21'd0) p2_in = cp;
                     done = 1'b1;
                  end else begin
                     emit_valid[1] = 1'b1; e_kind[1] = word_kind(p0_in, p1_in, p2_in, wc_in);
                     e_len[1] = wc_in; mode_in = MODE_IDLE;
                  end
               end
               MODE_AWORD: begin
                  if (!eof && (is_alpha(cp) || is_digit(cp) || cp == 21'h5F)) begin
                     wc_in = wsum[8] ? 8'hFF : wsum[7:0]; done = 1'b1;
                  end else begin
                     emit_valid[1] = 1'b1; e_kind[1] = K_IDENT; e_len[1] = wc_in;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_NUMBER: begin
                  if (!eof && (is_digit(cp) || cp == 21'h2E)) begin
                     if (cp == 21'h2E) begin
                        if (nf_in[0]) nf_in[1] = 1'b1;
                        nf_in[0] = 1'b1;
                     end else begin
                        nf_in[2] = 1'b1;
                     end
                     wc_in = wsum[8] ? 8'hFF : wsum[7:0]; done = 1'b1;
                  end else begin
                     emit_valid[1] = 1'b1; e_len[1] = wc_in;
                     if (wc_in == 8'd3 && !nf_in[2] && nf_in[1]) begin
                        e_kind[1] = K_VAARG;
                     end else if (nf_in[1]) begin
                        e_kind[1] = K_UNDEF;
                        e_err[1] = nf_in[2] ? ERR_BAD_REAL : ERR_NONE;
                     end else begin
                        e_kind[1] = nf_in[0] ? K_REAL : K_INT;
                     end
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_OPER: begin
                  plen = (op_in == 24'd0) ? 2'd0 : ((op_in[23:8] == 16'd0) ? 2'd1 :
                         ((op_in[23:16] == 8'd0) ? 2'd2 : 2'd3));
                  if (!eof && cp < 21'd128 && plen != 2'd3) begin
                     cand = op_in | ({16'd0, cp[7:0]} << {plen, 3'd0});
                     look = oper_lookup(cand);
                     if (look[6]) begin
                        op_in = cand; done = 1'b1;
                     end else if (cand == 24'h002B2B || cand == 24'h002D2D) begin
                        emit_valid[1] = 1'b1; e_kind[1] = K_UNDEF; e_len[1] = 8'd2;
                        e_err[1] = ERR_INCREMENT; mode_in = MODE_IDLE; done = 1'b1;
                     end
                  end
                  if (!done) begin
                     look = oper_lookup(op_in);
                     if (look[6] && look[5:0] == K_ANNO) begin
                        // comment body begins with this code point
                        if (!eof && cp != 21'h0A) done = 1'b1;
                        else mode_in = MODE_IDLE;
                        mode_in = done ? MODE_COMMENT : MODE_IDLE;
                     end else begin
                        emit_valid[1] = 1'b1; e_kind[1] = look[6] ? look[5:0] : K_UNDEF;
                        e_len[1] = {6'd0, plen}; mode_in = MODE_IDLE;
                     end
                  end
               end
               MODE_COMMENT: begin
                  if (!eof && cp != 21'h0A) done = 1'b1;
                  else mode_in = MODE_IDLE;
               end
               default: mode_in = MODE_IDLE;
            endcase
            if (emit_valid[1]) begin
               if (e_err[1] == ERR_NONE) e_err[1] = pend_in;
               pend_in = ERR_NONE;
            end
         end

         // start a new token
         if (!done) begin
            e_line[2] = line_in; e_col[2] = col_in;
            if (eof) begin
               emit_valid[2] = 1'b1; e_kind[2] = K_EOF; e_err[2] = pend_in;
               als_in = 1'b0; mode_in = MODE_IDLE; line_in = '0; col_in = '0;
               tl_in = '0; tc_in = '0; wc_in = 8'd0; p0_in = 21'd0; p1_in = 21'd0;
               p2_in = 21'd0; op_in = 24'd0; nf_in = 3'd0; sr_in = 3'd0;
               pend_in = ERR_NONE;
            end else if (!is_blank(cp)) begin
               tl_in = line_in; tc_in = col_in; wc_in = {5'd0, nb};
               look = oper_lookup({16'd0, cp[7:0]});
               if (cp == 21'h0A) begin
                  wc_in = 8'd0;
                  emit_valid[2] = 1'b1; e_kind[2] = K_NEWLINE; e_len[2] = 8'd1;
                  e_err[2] = pend_in; pend_in = ERR_NONE;
                  if (line_in != '1) line_in = line_in + 1'b1;
                  col_in = '0; als_in = 1'b1;
               end else if (is_kor(cp) || cp == 21'h5F) begin
                  p0_in = cp; p1_in = 21'd0; p2_in = 21'd0; mode_in = MODE_KWORD;
               end else if (is_alpha(cp)) begin
                  mode_in = MODE_AWORD;
               end else if (is_digit(cp) || cp == 21'h2E) begin
                  nf_in = (cp == 21'h2E) ? 3'd1 : 3'd4; mode_in = MODE_NUMBER;
               end else if (cp < 21'd128 && look[6]) begin
                  op_in = {16'd0, cp[7:0]}; mode_in = MODE_OPER;
               end else begin
                  emit_valid[2] = 1'b1; e_kind[2] = K_UNDEF; e_len[2] = {5'd0, nb};
                  e_err[2] = pend_in; pend_in = ERR_NONE;
               end
            end
         end
      end

      emit_data[0] = {e_kind[0], e_line[0], e_col[0], e_len[0], e_err[0],
                      ~(emit_valid[1] | emit_valid[2])};
      emit_data[1] = {e_kind[1], e_line[1], e_col[1], e_len[1], e_err[1], ~emit_valid[2]};
      emit_data[2] = {e_kind[2], e_line[2], e_col[2], e_len[2], e_err[2], 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= INDENT_WIDTH_RESET; als_ff <= 1'b0; mode_ff <= MODE_IDLE;
         acc_ff <= '0; left_ff <= '0; ulen_ff <= '0; line_ff <= '0; col_ff <= '0;
         tl_ff <= '0; tc_ff <= '0; wc_ff <= '0; p0_ff <= '0; p1_ff <= '0; p2_ff <= '0;
         op_ff <= '0; nf_ff <= '0; sr_ff <= '0; pend_ff <= '0;
      end else begin
         if (cfg_write) iw_ff <= cfg_data;
         als_ff <= als_in; mode_ff <= mode_in; acc_ff <= acc_in; left_ff <= left_in;
         ulen_ff <= ulen_in; line_ff <= line_in; col_ff <= col_in; tl_ff <= tl_in;
         tc_ff <= tc_in; wc_ff <= wc_in; p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
         op_ff <= op_in; nf_ff <= nf_in; sr_ff <= sr_in; pend_ff <= pend_in;
      end
   end

endmodule

// ===== rtl/hst_rsp_queue.sv =====
// 4-entry token queue: up to three in, one out unless stalled, per cycle
`timescale 1ns / 1ps
module hst_rsp_queue #(
   parameter int WIDTH = 46
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [hst_pkg::MAX_EMITS-1:0]          push_valid,
   input  logic [hst_pkg::MAX_EMITS-1:0][WIDTH-1:0] push_data,
   output logic                                   room,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output logic [WIDTH-1:0]                       out_data
);
   import hst_pkg::*;

   logic [WIDTH-1:0] mem_ff [4];
   logic [1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [2:0]       count_ff, count_in;
   logic [1:0]       pos [3];
   logic             pop;

   always_comb begin
      pop = (count_ff != 3'd0) && !out_stall;
      pos[0] = tail_ff;
      pos[1] = tail_ff + {1'b0, push_valid[0]};
      pos[2] = pos[1] + {1'b0, push_valid[1]};
      tail_in = pos[2] + {1'b0, push_valid[2]};
      head_in = head_ff + {1'b0, pop};
      count_in = count_ff - {2'd0, pop} + {2'd0, push_valid[0]} + {2'd0, push_valid[1]}
                 + {2'd0, push_valid[2]};
   end

   // three free entries needed without counting this cycle's pop
   assign room      = count_ff <= 3'd1;
   assign out_valid = count_ff != 3'd0;
   assign out_data  = mem_ff[head_ff];

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_EMITS; i++) begin
         if (push_valid[i]) mem_ff[pos[i]] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0; tail_ff <= '0; count_ff <= '0;
      end else begin
         head_ff <= head_in; tail_ff <= tail_in; count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/hangul_source_tokenizer.sv =====
// top level: streaming tokenizer for utf-8 hangul source text
//
// req channel carries one source byte (req_action 0) or end of input
// (req_action 1) per transaction; a transaction is taken when req_valid is
// high and req_stall low. rsp channel returns tokens with kind, start line,
// start column, byte length, error code and a flag on the last token that a
// transaction produced. csr channel writes indent_width; csr_ready is always
// high and writes belong only where no transaction is in flight.
// a byte is lexed in the cycle it is taken and its tokens (zero to three)
// sit in a four-entry queue; the first reaches rsp no sooner than the next
// cycle. one byte per cycle is sustained while each byte yields at most one
// token and the receiver keeps up; a byte that yields several tokens holds
// req_stall while the queue drains one token a cycle.
// when the receiver stalls the queue fills and req_stall rises once fewer
// than three entries are free. reset clears position, lexer state and the
// queue and sets indent_width to 4.
`timescale 1ns / 1ps
module hangul_source_tokenizer #(
   parameter int LINE_BITS   = hst_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = hst_pkg::COLUMN_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [5:0]             rsp_token_kind,
   output logic [LINE_BITS-1:0]   rsp_start_line,
   output logic [COLUMN_BITS-1:0] rsp_start_column,
   output logic [7:0]             rsp_byte_length,
   output logic [2:0]             rsp_error_code,
   output logic                   rsp_last_result,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [3:0]             csr_indent_width
);
   import hst_pkg::*;

   localparam int EW = 6 + LINE_BITS + COLUMN_BITS + 8 + 3 + 1;

   logic                         room, step;
   logic [MAX_EMITS-1:0]         emit_valid;
   logic [MAX_EMITS-1:0][EW-1:0] emit_data;
   logic [EW-1:0]                head_data;

   assign req_stall = !room;
   assign step      = req_valid && room;
   assign csr_ready = 1'b1;

   hst_lexer #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .EW(EW)) u_lexer (
      .clock(clock), .reset(reset), .step(step), .action(req_action),
      .data_byte(req_data_byte), .cfg_write(csr_valid), .cfg_data(csr_indent_width),
      .emit_valid(emit_valid), .emit_data(emit_data)
   );

   hst_rsp_queue #(.WIDTH(EW)) u_queue (
      .clock(clock), .reset(reset), .push_valid(emit_valid & {MAX_EMITS{step}}),
      .push_data(emit_data), .room(room), .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_data(head_data)
   );

   assign {rsp_token_kind, rsp_start_line, rsp_start_column, rsp_byte_length,
           rsp_error_code, rsp_last_result} = head_data;

endmodule
